// ===== src/tape_block_framer_assert.svh =====
// assertion macros for the tape block framer
// clocked on clk_i, disabled while rst_ni is low
`ifndef TAPE_BLOCK_FRAMER_ASSERT_SVH
`define TAPE_BLOCK_FRAMER_ASSERT_SVH

// property must hold at every edge
`define TBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen
`define TBF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/tbf_pkg.sv =====
`default_nettype none

package tbf_pkg;

  // payload bytes per tape block
  localparam int unsigned TBF_PAYLOAD_BYTES = 32;

  // address word of the header block
  localparam logic [15:0] TBF_HDR_ADDR = 16'h00E0;

endpackage

`default_nettype wire

// ===== src/tape_block_framer.sv =====
// the input word is held in an item register, and each result word leaves through the output register
// throughput: one output word per cycle unless the output stalls; a word opening a block gives 3 results,
// a word filling a block gives 3, a final word before a full block gives
// 3 + pad count (2 more when that word also opens the block), all others give 1,
// so the output port sets the pace
// reset: asynchronous active low, clears all framing state to a new header block
`default_nettype none

module tape_block_framer
  import tbf_pkg::*;
#(
  parameter int unsigned PayloadBytes = TBF_PAYLOAD_BYTES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // image word input
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       is_last_i,
  // framed word output
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            block_end_o,
  output logic            run_last_o,
  output logic            stream_end_o
);

  `include "tape_block_framer_assert.svh"

  localparam int unsigned PosW = $clog2(PayloadBytes);
  localparam logic [PosW-1:0] PosMax = PosW'(PayloadBytes - 1);
  localparam logic [15:0] AddrStep = 16'(PayloadBytes);

  // emit sequencer codes
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_ADDR_LO = 3'd1;
  localparam logic [2:0] PH_ADDR_HI = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_PAD     = 3'd4;
  localparam logic [2:0] PH_CKS_LO  = 3'd5;
  localparam logic [2:0] PH_CKS_HI  = 3'd6;

  // framing state
  logic [PosW-1:0] pos_q, pos_d;
  logic            hdr_q, hdr_d;
  logic [15:0]     load_q, load_d;
  logic [15:0]     nxt_q, nxt_d;
  logic [15:0]     sum_q, sum_d;

  // held input word and its place in the emit sequence
  logic       item_vld_q, item_vld_d;
  logic [7:0] item_byte_q, item_byte_d;
  logic       item_last_q, item_last_d;
  logic [2:0] phase_q, phase_d;

  // output register
  logic       out_vld_q, out_vld_d;
  logic [7:0] obyte_q, obyte_d;
  logic       bend_q, bend_d;
  logic       rlast_q, rlast_d;
  logic       send_q, send_d;

  logic [2:0]  ph;
  logic [2:0]  ph_next;
  logic        emit;
  logic        final_w;
  logic        take;
  logic [15:0] blk_addr;

  // one result word per cycle whenever the output register frees up
  assign emit = item_vld_q && (!out_vld_q || !out_stall_i);
  // input stalls only while the held word still has results to go
  assign in_stall_o = item_vld_q && !(emit && final_w);
  assign take = in_valid_i && !in_stall_o;

  assign blk_addr = hdr_q ? TBF_HDR_ADDR : nxt_q;

  // a new word opens a block with the address, otherwise goes straight to data
  always_comb begin
    ph = phase_q;
    if (phase_q == PH_START) begin
      ph = (pos_q == '0) ? PH_ADDR_LO : PH_DATA;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    load_d  = load_q;
    nxt_d   = nxt_q;
    sum_d   = sum_q;
    ph_next = ph;
    final_w = 1'b0;
    obyte_d = obyte_q;
    bend_d  = bend_q;
    rlast_d = rlast_q;
    send_d  = send_q;

    case (ph)
      PH_ADDR_LO: begin
        obyte_d = blk_addr[7:0];
        sum_d   = blk_addr;
        ph_next = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        obyte_d = blk_addr[15:8];
        ph_next = PH_DATA;
      end
      PH_DATA: begin
        obyte_d = item_byte_q;
        // load address sits in the first two header bytes
        if (hdr_q && pos_q == '0) begin
          load_d[7:0] = item_byte_q;
        end else if (hdr_q && pos_q == PosW'(1)) begin
          load_d[15:8] = item_byte_q;
        end
        sum_d = pos_q[0] ? sum_q + {item_byte_q, 8'h00} : sum_q + {8'h00, item_byte_q};
        pos_d = pos_q + PosW'(1);
        if (pos_q == PosMax) begin
          ph_next = PH_CKS_LO;
        end else if (item_last_q) begin
          ph_next = PH_PAD;
        end else begin
          final_w = 1'b1;
        end
      end
      PH_PAD: begin
        // zero fill of a short final block
        obyte_d = 8'h00;
        pos_d   = pos_q + PosW'(1);
        if (pos_q == PosMax) begin
          ph_next = PH_CKS_LO;
        end
      end
      PH_CKS_LO: begin
        obyte_d = sum_q[7:0];
        ph_next = PH_CKS_HI;
      end
      PH_CKS_HI: begin
        obyte_d = sum_q[15:8];
        final_w = 1'b1;
        pos_d   = '0;
        sum_d   = '0;
        if (hdr_q) begin
          hdr_d = 1'b0;
          nxt_d = load_q;
        end else begin
          nxt_d = nxt_q + AddrStep;
        end
        // end of image, back to a fresh header block
        if (item_last_q) begin
          hdr_d  = 1'b1;
          load_d = '0;
          nxt_d  = '0;
        end
      end
      default: begin
        ph_next = PH_START;
      end
    endcase

    bend_d  = (ph == PH_CKS_HI);
    send_d  = (ph == PH_CKS_HI) && item_last_q;
    rlast_d = final_w;

    // hold everything unless a word really goes out this cycle
    if (!emit) begin
      pos_d   = pos_q;
      hdr_d   = hdr_q;
      load_d  = load_q;
      nxt_d   = nxt_q;
      sum_d   = sum_q;
      obyte_d = obyte_q;
      bend_d  = bend_q;
      rlast_d = rlast_q;
      send_d  = send_q;
    end
  end

  always_comb begin
    item_vld_d  = item_vld_q;
    item_byte_d = item_byte_q;
    item_last_d = item_last_q;
    phase_d     = phase_q;
    if (take) begin
      item_vld_d  = 1'b1;
      item_byte_d = data_byte_i;
      item_last_d = is_last_i;
      phase_d     = PH_START;
    end else if (emit && final_w) begin
      item_vld_d = 1'b0;
      phase_d    = PH_START;
    end else if (emit) begin
      phase_d = ph_next;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_q      <= 1'b1;
      load_q     <= '0;
      nxt_q      <= '0;
      sum_q      <= '0;
      item_vld_q <= 1'b0;
      phase_q    <= PH_START;
      out_vld_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      hdr_q      <= hdr_d;
      load_q     <= load_d;
      nxt_q      <= nxt_d;
      sum_q      <= sum_d;
      item_vld_q <= item_vld_d;
      phase_q    <= phase_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_byte_q <= item_byte_d;
    item_last_q <= item_last_d;
    obyte_q     <= obyte_d;
    bend_q      <= bend_d;
    rlast_q     <= rlast_d;
    send_q      <= send_d;
  end

  assign out_valid_o  = out_vld_q;
  assign out_byte_o   = obyte_q;
  assign block_end_o  = bend_q;
  assign run_last_o   = rlast_q;
  assign stream_end_o = send_q;

  `TBF_ASSERT(a_bend_ends_run, out_vld_q && bend_q |-> rlast_q, "block end without run end")
  `TBF_ASSERT(a_send_is_bend, out_vld_q && send_q |-> bend_q, "stream end off a block end")
  `TBF_ASSERT_NEVER(a_pad_not_last, item_vld_q && phase_q == PH_PAD && !item_last_q, "padding inside an image")
  `TBF_ASSERT(a_reset_after_end, emit && ph == PH_CKS_HI && item_last_q |=> hdr_q && pos_q == '0 && sum_q == '0, "no return to header block after image end")

endmodule

`default_nettype wire

// ===== tb/sv/tb_tape_block_framer.sv =====
`timescale 1ns / 1ps

module tb_tape_block_framer;
  import tbf_pkg::*;

  // idle cycles with no word moving on either side before giving up
  localparam int IDLE_LIMIT = 2000;
  // quiet cycles after the last expected word, to catch stray output
  localparam int SETTLE_CYCLES = 16;
  // random image words to send after the directed rows
  localparam int RANDOM_WORDS = 216;
  // cap on printed mismatch lines, counting goes on past it
  localparam int MAX_REPORTS = 30;

  // one framed word as seen on the output port
  typedef struct packed {
    logic [7:0] data;
    logic       blk_end;
    logic       run_last;
    logic       strm_end;
  } framed_word_t;

  // directed row: image word plus framed words typed in by hand
  // n_typed == 0 means the row is checked against the framer model
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    int          n_typed;
    logic [23:0] typed;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_e;

  localparam int DIR_ROWS = 14;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // header block opens right after reset: address e0 00, then the word
    '{8'h00, 1'b0, 3, 24'hE00000},
    '{8'hFF, 1'b0, 1, 24'hFF0000},
    '{8'h01, 1'b0, 1, 24'h010000},
    // short header closed by last: zero padding and checksum
    '{8'h80, 1'b1, 0, 24'h000000},
    // one-word images, load address never completed
    '{8'hFF, 1'b1, 0, 24'h000000},
    '{8'h00, 1'b1, 0, 24'h000000},
    // back at a fresh header after each last
    '{8'hA5, 1'b0, 3, 24'hE000A5},
    '{8'h5A, 1'b1, 0, 24'h000000},
    '{8'h7F, 1'b0, 3, 24'hE0007F},
    '{8'h80, 1'b0, 1, 24'h800000},
    '{8'h55, 1'b0, 1, 24'h550000},
    '{8'hAA, 1'b0, 1, 24'hAA0000},
    '{8'hFE, 1'b0, 1, 24'hFE0000},
    '{8'h01, 1'b1, 0, 24'h000000}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       is_last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       block_end_o;
  logic       run_last_o;
  logic       stream_end_o;

  // framed words still owed by the block, oldest first
  framed_word_t framed_due[$];
  // words produced by the model for the word just accepted
  framed_word_t fresh_words[$];
  framed_word_t due_word;

  // framer model state
  int unsigned fr_pos;
  logic        fr_in_header;
  logic [15:0] fr_load_addr;
  logic [15:0] fr_next_addr;
  logic [15:0] fr_sum;

  // sender burst control
  int burst_left = 0;
  bit quiet = 1'b0;

  // receiver stall pattern
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;

  int fail_count = 0;
  int idle_cycles = 0;
  int words_in = 0;
  int words_out = 0;
  int blocks_out = 0;
  int images_done = 0;
  int wrap_images = 0;

  tape_block_framer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .block_end_o (block_end_o),
    .run_last_o  (run_last_o),
    .stream_end_o(stream_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------
  // framer model
  // ---------------------------------------------------------------

  function automatic void framer_clear();
    fr_pos       = 0;
    fr_in_header = 1'b1;
    fr_load_addr = '0;
    fr_next_addr = '0;
    fr_sum       = '0;
  endfunction

  function automatic void emit_word(logic [7:0] data, logic blk_end, logic strm_end);
    framed_word_t w;
    w.data     = data;
    w.blk_end  = blk_end;
    w.run_last = 1'b0;
    w.strm_end = strm_end;
    fresh_words.push_back(w);
  endfunction

  // frame one image word: fills fresh_words with what it causes
  function automatic void frame_image_word(logic [7:0] b, logic last);
    logic [15:0] addr;
    fresh_words.delete();
    // a new block opens with its address word, low byte first
    if (fr_pos == 0) begin
      addr   = fr_in_header ? TBF_HDR_ADDR : fr_next_addr;
      fr_sum = addr;
      emit_word(addr[7:0], 1'b0, 1'b0);
      emit_word(addr[15:8], 1'b0, 1'b0);
    end
    // load address sits in the first two header words
    if (fr_in_header) begin
      if (fr_pos == 0) begin
        fr_load_addr[7:0] = b;
      end else if (fr_pos == 1) begin
        fr_load_addr[15:8] = b;
      end
    end
    // checksum adds little-endian words: odd positions are high bytes
    fr_sum = fr_sum + (fr_pos[0] ? {b, 8'h00} : {8'h00, b});
    emit_word(b, 1'b0, 1'b0);
    fr_pos++;
    if (fr_pos >= TBF_PAYLOAD_BYTES || last) begin
      // pad a short final block with zeros
      while (fr_pos < TBF_PAYLOAD_BYTES) begin
        emit_word(8'h00, 1'b0, 1'b0);
        fr_pos++;
      end
      emit_word(fr_sum[7:0], 1'b0, 1'b0);
      emit_word(fr_sum[15:8], 1'b1, last);
      if (fr_in_header) begin
        fr_in_header = 1'b0;
        fr_next_addr = fr_load_addr;
      end else begin
        fr_next_addr = fr_next_addr + 16'(TBF_PAYLOAD_BYTES);
      end
      fr_pos = 0;
      fr_sum = '0;
      // end of image: next word starts a new header
      if (last) framer_clear();
    end
    fresh_words[fresh_words.size() - 1].run_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < MAX_REPORTS) begin
      $display("[%0t] mismatch on %s at framed word %0d: got %0h, expected %0h",
               $realtime, what, words_out, got, want);
    end
    fail_count++;
  endtask

  // output monitor: every accepted word is matched with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (block_end_o) blocks_out++;
      if (framed_due.size() == 0) begin
        report_mismatch("unexpected word", out_byte_o, 0);
      end else begin
        due_word = framed_due.pop_front();
        if (out_byte_o !== due_word.data)
          report_mismatch("out_byte", out_byte_o, due_word.data);
        if (block_end_o !== due_word.blk_end)
          report_mismatch("block_end", block_end_o, due_word.blk_end);
        if (run_last_o !== due_word.run_last)
          report_mismatch("run_last", run_last_o, due_word.run_last);
        if (stream_end_o !== due_word.strm_end)
          report_mismatch("stream_end", stream_end_o, due_word.strm_end);
      end
      words_out++;
    end
  end

  // ---------------------------------------------------------------
  // receiver stall pattern, switches at random among four styles
  // ---------------------------------------------------------------

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 128 == 0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall_i <= (stall_tick % 4 == 3);
      STALL_LONG:     out_stall_i <= stall_tick[3];
      default:        out_stall_i <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------
  // watchdog: nothing moving for too long ends the run
  // ---------------------------------------------------------------

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles, %0d framed words still due",
             IDLE_LIMIT, framed_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------

  // offer one image word, bursts and gaps decided here
  task automatic send_word(input logic [7:0] b, input logic last,
                           input int n_typed, input logic [23:0] typed);
    int gap;
    int i;
    framed_word_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    is_last_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    words_in++;
    frame_image_word(b, last);
    if (n_typed == 0) begin
      foreach (fresh_words[k]) framed_due.push_back(fresh_words[k]);
    end else begin
      // hand-typed expectation, model state still advances
      for (i = 0; i < n_typed; i++) begin
        w.data     = typed[23 - 8 * i -: 8];
        w.blk_end  = 1'b0;
        w.run_last = (i == n_typed - 1);
        w.strm_end = 1'b0;
        framed_due.push_back(w);
      end
    end
  endtask

  // hold the sender until every owed word has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (framed_due.size() != 0);
  endtask

  initial begin
    int random_sent;
    int len;
    int j;
    logic [15:0] load;
    logic [7:0] b;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    is_last_i   = 1'b0;
    random_sent = 0;
    framer_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: header opening, short images, extremes of the word
    foreach (DIRECTED_ROWS[r]) begin
      send_word(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last,
                DIRECTED_ROWS[r].n_typed, DIRECTED_ROWS[r].typed);
      if (DIRECTED_ROWS[r].last) images_done++;
    end
    wait_drained();

    // random images: mostly full header plus data blocks, some short ones
    while (random_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, 31);
        1:       len = TBF_PAYLOAD_BYTES;
        2:       len = 2 * TBF_PAYLOAD_BYTES;
        3:       len = 2 * TBF_PAYLOAD_BYTES + 1;
        default: len = $urandom_range(33, 110);
      endcase
      // the last image is cut to what is left of the word budget
      if (len > RANDOM_WORDS - random_sent) len = RANDOM_WORDS - random_sent;
      // a third of the loads sit near the top so block addresses wrap
      if ($urandom_range(0, 2) == 0) begin
        load = 16'hFFFF - 16'($urandom_range(0, 95));
        wrap_images++;
      end else begin
        load = 16'($urandom);
      end
      quiet = ($urandom_range(0, 4) == 0);
      for (j = 0; j < len; j++) begin
        b = 8'($urandom);
        if (j == 0) b = load[7:0];
        if (j == 1) b = load[15:8];
        send_word(b, (j == len - 1), 0, 24'h000000);
        random_sent++;
      end
      images_done++;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d images (%0d with load near the top of memory), %0d image words",
             images_done, wrap_images, words_in);
    $display("checked %0d framed words in %0d blocks, %0d mismatches",
             words_out, blocks_out, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
